// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the byte budget queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BBQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bbq_pkg.sv
// ----------------------------------------------------------------------------
// bbq_pkg
// Types, codes and defaults shared by the byte budget queue modules
// ----------------------------------------------------------------------------
package bbq_pkg;

    // default sizing
    localparam int DEPTH_DEFAULT      = 32;
    localparam int TAG_WIDTH_DEFAULT  = 32;
    localparam int SIZE_WIDTH_DEFAULT = 32;

    // fixed field widths
    localparam int OPER_W  = 2;
    localparam int FIELD_W = 32;
    localparam int KIND_W  = 3;

    // register port
    localparam int          ADDR_W          = 3;
    localparam int          DATA_W          = 32;
    localparam logic        REG_MAX_BYTES   = 1'b0;
    localparam logic [31:0] MAX_BYTES_RESET = 32'd1048576;

    // front to back command queue depth (power of two)
    localparam int CMDQ_DEPTH = 2;

    // request operation codes
    localparam logic [OPER_W-1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [OPER_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OPER_W-1:0] OP_POP_FRONT  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EVICTED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POPPED   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

    // classified command handed from front to back
    typedef enum logic [1:0] {
        CMD_PUSH_BACK  = 2'd0,
        CMD_PUSH_FRONT = 2'd1,
        CMD_POP        = 2'd2,
        CMD_REJECT     = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [OPER_W-1:0]  operation;
        logic [FIELD_W-1:0] task_tag;
        logic [FIELD_W-1:0] task_size;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] out_tag;
        logic [FIELD_W-1:0] out_size;
        logic [FIELD_W-1:0] bytes_in_use;
        logic               last;
    } rsp_t;

endpackage

// File: src/bbq_ram.sv
// ----------------------------------------------------------------------------
// bbq_ram
// Generic single write port, single read port RAM with registered read
// ----------------------------------------------------------------------------
module bbq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/bbq_front.sv
// ----------------------------------------------------------------------------
// bbq_front
// Accepts requests, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module bbq_front
    import bbq_pkg::*;
#(
    parameter int TAG_WIDTH  = TAG_WIDTH_DEFAULT,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    input  logic [31:0]           max_bytes,
    output logic                  cmd_valid,
    input  logic                  cmd_take,
    output cmd_kind_t             cmd_kind,
    output logic [TAG_WIDTH-1:0]  cmd_tag,
    output logic [SIZE_WIDTH-1:0] cmd_size
);

    localparam int TW_EXT = (TAG_WIDTH > FIELD_W) ? TAG_WIDTH : FIELD_W;
    localparam int SW_EXT = (SIZE_WIDTH > FIELD_W) ? SIZE_WIDTH : FIELD_W;
    localparam int PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

    logic [TW_EXT-1:0]     tag_ext;
    logic [SW_EXT-1:0]     size_ext;
    logic [SW_EXT-1:0]     size_back;
    logic [TAG_WIDTH-1:0]  tag_w;
    logic [SIZE_WIDTH-1:0] size_w;
    logic [31:0]           size32;
    cmd_kind_t             kind_c;
    logic                  push;

    cmd_kind_t             kind_q [CMDQ_DEPTH];
    logic [TAG_WIDTH-1:0]  tag_q  [CMDQ_DEPTH];
    logic [SIZE_WIDTH-1:0] size_q [CMDQ_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;

    // fit the request fields to the stored widths
    assign tag_ext   = TW_EXT'(req.task_tag);
    assign tag_w     = tag_ext[TAG_WIDTH-1:0];
    assign size_ext  = SW_EXT'(req.task_size);
    assign size_w    = size_ext[SIZE_WIDTH-1:0];
    assign size_back = SW_EXT'(size_w);
    assign size32    = size_back[31:0];

    // classify: bad codes and oversized back pushes are rejected here
    always_comb
    begin
        case (req.operation)
            OP_PUSH_BACK:  kind_c = (size32 > max_bytes) ? CMD_REJECT : CMD_PUSH_BACK;
            OP_PUSH_FRONT: kind_c = CMD_PUSH_FRONT;
            OP_POP_FRONT:  kind_c = CMD_POP;
            default:       kind_c = CMD_REJECT;
        endcase
    end

    // command queue control
    assign req_ready = (cnt_reg != QCNT_W'(CMDQ_DEPTH));
    assign push      = req_valid && req_ready;
    assign cmd_valid = (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(cmd_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // command queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_q[wr_ptr_reg] <= kind_c;
            tag_q[wr_ptr_reg]  <= tag_w;
            size_q[wr_ptr_reg] <= size_w;
        end
    end

    assign cmd_kind = kind_q[rd_ptr_reg];
    assign cmd_tag  = tag_q[rd_ptr_reg];
    assign cmd_size = size_q[rd_ptr_reg];

endmodule

// File: src/bbq_back.sv
// ----------------------------------------------------------------------------
// bbq_back
// Executes queued commands against the entry store and drives results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbq_back
    import bbq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int TAG_WIDTH  = TAG_WIDTH_DEFAULT,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           max_bytes,
    input  logic                  cmd_valid,
    output logic                  cmd_take,
    input  cmd_kind_t             cmd_kind,
    input  logic [TAG_WIDTH-1:0]  cmd_tag,
    input  logic [SIZE_WIDTH-1:0] cmd_size,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int TW_EXT = (TAG_WIDTH > FIELD_W) ? TAG_WIDTH : FIELD_W;
    localparam int SW_EXT = (SIZE_WIDTH > FIELD_W) ? SIZE_WIDTH : FIELD_W;
    localparam int MEM_W  = TAG_WIDTH + SIZE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_READ = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [31:0]           used_reg, used_next;
    cmd_kind_t             cur_kind_reg;
    logic [TAG_WIDTH-1:0]  cur_tag_reg;
    logic [SIZE_WIDTH-1:0] cur_size_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg, rsp_next;
    logic                  rsp_load;
    logic                  can_emit;

    logic [SW_EXT-1:0]     cur_size_ext;
    logic [32:0]           sum33;
    logic                  over_budget;
    logic                  full;
    logic                  empty;
    logic [IDX_W-1:0]      head_inc, head_dec;
    logic [CNT_W:0]        tail_sum, tail_wrap;
    logic [IDX_W-1:0]      tail;

    logic                  wr_en, rd_en;
    logic [IDX_W-1:0]      wr_addr, rd_addr;
    logic [MEM_W-1:0]      wr_data, rd_data;
    logic [TW_EXT-1:0]     rd_tag_ext;
    logic [SW_EXT-1:0]     rd_size_ext;
    logic [31:0]           rd_tag32, rd_size32;

    // entry store, tag above size
    bbq_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_tag_ext  = TW_EXT'(rd_data[MEM_W-1:SIZE_WIDTH]);
    assign rd_size_ext = SW_EXT'(rd_data[SIZE_WIDTH-1:0]);
    assign rd_tag32    = rd_tag_ext[31:0];
    assign rd_size32   = rd_size_ext[31:0];

    // budget and occupancy checks for the current command
    assign cur_size_ext = SW_EXT'(cur_size_reg);
    assign sum33        = {1'b0, used_reg} + {1'b0, cur_size_ext[31:0]};
    assign over_budget  = sum33 > {1'b0, max_bytes};
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);

    // ring index arithmetic
    assign head_inc  = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign tail_sum  = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(DEPTH)) ? tail_sum - (CNT_W+1)'(DEPTH)
                                                       : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];

    assign can_emit = !rsp_valid_reg || rsp_ready;

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        used_next  = used_reg;
        cmd_take   = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = tail;
        wr_data    = {cur_tag_reg, cur_size_reg};
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        rsp_load   = 1'b0;
        rsp_next   = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                case (cur_kind_reg)
                    CMD_POP:
                    begin
                        if (!empty)
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                        else if (can_emit)
                        begin
                            rsp_load      = 1'b1;
                            rsp_next.kind = KIND_EMPTY;
                            state_next    = S_IDLE;
                        end
                    end

                    CMD_PUSH_BACK:
                    begin
                        // evict from the head until the item fits and a slot is free
                        if (!empty && (over_budget || full))
                        begin
                            rd_en      = 1'b1;
                            state_next = S_READ;
                        end
                        else if (can_emit)
                        begin
                            wr_en         = 1'b1;
                            count_next    = count_reg + 1'b1;
                            used_next     = sum33[31:0];
                            rsp_load      = 1'b1;
                            rsp_next.kind = KIND_ACCEPTED;
                            state_next    = S_IDLE;
                        end
                    end

                    CMD_PUSH_FRONT:
                    begin
                        if (can_emit)
                        begin
                            rsp_load   = 1'b1;
                            state_next = S_IDLE;
                            if (over_budget || full)
                            begin
                                rsp_next.kind = KIND_REJECTED;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_addr       = head_dec;
                                head_next     = head_dec;
                                count_next    = count_reg + 1'b1;
                                used_next     = sum33[31:0];
                                rsp_next.kind = KIND_ACCEPTED;
                            end
                        end
                    end

                    default:
                    begin
                        if (can_emit)
                        begin
                            rsp_load      = 1'b1;
                            rsp_next.kind = KIND_REJECTED;
                            state_next    = S_IDLE;
                        end
                    end
                endcase
            end

            S_READ:
            begin
                // head entry data is in the read register
                if (can_emit)
                begin
                    rsp_load          = 1'b1;
                    head_next         = head_inc;
                    count_next        = count_reg - 1'b1;
                    used_next         = used_reg - rd_size32;
                    rsp_next.out_tag  = rd_tag32;
                    rsp_next.out_size = rd_size32;
                    if (cur_kind_reg == CMD_POP)
                    begin
                        rsp_next.kind = KIND_POPPED;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        rsp_next.kind = KIND_EVICTED;
                        state_next    = S_EXEC;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.bytes_in_use = used_next;
        rsp_next.last         = (rsp_next.kind != KIND_EVICTED);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // current command and result payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_kind_reg <= cmd_kind;
            cur_tag_reg  <= cmd_tag;
            cur_size_reg <= cmd_size;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `BBQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH), "entry count above depth")
    `BBQ_ASSERT_IMP(a_read_nonempty, clk, rst_n, state_reg == S_READ, count_reg != '0, "head read on empty queue")
    `BBQ_ASSERT_NXT(a_used_with_result, clk, rst_n, !rsp_load, $stable(used_reg), "byte count moved without a result")
    `BBQ_ASSERT_NXT(a_take_to_exec, clk, rst_n, cmd_take, state_reg == S_EXEC, "taken command not executed")

endmodule

// File: src/byte_budget_queue_drop_oldest.sv
// ----------------------------------------------------------------------------
// byte_budget_queue_drop_oldest
// Double-ended descriptor queue with a byte budget and drop-oldest eviction
// ----------------------------------------------------------------------------
// Usage:
//   Requests (push back, push front, pop front) enter on req_valid/req_ready
//   and are classified into a two-entry command queue, so the front keeps
//   taking requests while the back end works or the result side stalls.
//   Each request produces one or more results on rsp_valid/rsp_ready; the
//   final one has last set. A push to the back first evicts head entries,
//   one evicted result each, until the item fits the budget and a slot is
//   free. The budget register max_bytes sits at address 0 of the APB port
//   and must be written only while the block is idle; the block does not
//   enforce this. A request is registered in the command queue, taken by
//   the back end once it is idle and executed; its results are registered.
//   A pop that returns an entry, and each evicted entry, also pass through
//   the registered read of the entry RAM. The back end takes a new command
//   only after the last result of the current one is loaded. Reset empties
//   the queue at once (no clearing pass) and loads the budget with 1048576.
//   A stalled receiver holds the result register; the back end waits and
//   the command queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module byte_budget_queue_drop_oldest
    import bbq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int TAG_WIDTH  = TAG_WIDTH_DEFAULT,
    parameter int SIZE_WIDTH = SIZE_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [31:0]           max_bytes_reg;
    logic                  cmd_valid;
    logic                  cmd_take;
    cmd_kind_t             cmd_kind;
    logic [TAG_WIDTH-1:0]  cmd_tag;
    logic [SIZE_WIDTH-1:0] cmd_size;
    logic                  reg_write;

    // budget register
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end
        else if (reg_write)
        begin
            max_bytes_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_MAX_BYTES) ? max_bytes_reg : '0;

    // request intake and classification
    bbq_front #(
        .TAG_WIDTH  (TAG_WIDTH),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .max_bytes (max_bytes_reg),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_kind  (cmd_kind),
        .cmd_tag   (cmd_tag),
        .cmd_size  (cmd_size)
    );

    // command execution and results
    bbq_back #(
        .DEPTH      (DEPTH),
        .TAG_WIDTH  (TAG_WIDTH),
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_bytes (max_bytes_reg),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_kind  (cmd_kind),
        .cmd_tag   (cmd_tag),
        .cmd_size  (cmd_size),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
